// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset
`define TFN_ASSERT_IMPL(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled in reset
`define TFN_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: hw/rtl/tfn_pkg.sv
// Types and constants of the triangle face normal pipeline
package tfn_pkg;

    localparam int COORD_W    = 16;
    localparam int EDGE_W     = COORD_W + 1;
    localparam int PROD_W     = 2 * EDGE_W;
    localparam int CROSS_W    = PROD_W + 1;
    localparam int MAG_W      = PROD_W;
    localparam int NORM_W     = (MAG_W < 31) ? 31 : MAG_W;
    localparam int NORM_STEPS = $clog2(NORM_W);
    localparam int R_W        = 31;
    localparam int SQ_W       = 2 * R_W;
    localparam int SUM_W      = 64;
    localparam int ROOT_W     = 32;
    localparam int REM_W      = 35;
    localparam int QUO_W      = 15;
    localparam int FRAC_SH    = 14;
    localparam int NUM_W      = R_W + FRAC_SH + 1;
    localparam int OUT_W      = 16;
    localparam logic [QUO_W-1:0] NORM_ONE = QUO_W'(16384);

    typedef struct packed {
        logic [COORD_W-1:0] v0_x;
        logic [COORD_W-1:0] v0_y;
        logic [COORD_W-1:0] v0_z;
        logic [COORD_W-1:0] v1_x;
        logic [COORD_W-1:0] v1_y;
        logic [COORD_W-1:0] v1_z;
        logic [COORD_W-1:0] v2_x;
        logic [COORD_W-1:0] v2_y;
        logic [COORD_W-1:0] v2_z;
    } in_t;

    typedef struct packed {
        logic [OUT_W-1:0] normal_x;
        logic [OUT_W-1:0] normal_y;
        logic [OUT_W-1:0] normal_z;
        logic             degenerate;
    } out_t;

    typedef struct packed {
        logic       valid;
        logic [2:0] neg;
        logic       degen;
    } ctl_t;

endpackage

// File: hw/rtl/tfn_front.sv
// Edges, cross product and component magnitudes
module tfn_front (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  en,
    input  logic                                  in_valid,
    input  tfn_pkg::in_t                          in_data,
    output tfn_pkg::ctl_t                         out_ctl,
    output logic [2:0][tfn_pkg::MAG_W-1:0]        out_mag
);

    localparam int EW = tfn_pkg::EDGE_W;
    localparam int PW = tfn_pkg::PROD_W;
    localparam int CW = tfn_pkg::CROSS_W;
    localparam int MW = tfn_pkg::MAG_W;

    logic                        e_valid_reg, p_valid_reg, c_valid_reg;
    logic signed [EW-1:0]        ax_reg, ay_reg, az_reg, bx_reg, by_reg, bz_reg;
    logic signed [5:0][PW-1:0]   prod_reg;
    logic signed [2:0][CW-1:0]   cross_reg;
    tfn_pkg::ctl_t               ctl_reg;
    logic [2:0][MW-1:0]          mag_reg;
    logic [2:0][MW-1:0]          mag_next;
    logic [2:0]                  neg_next;

    function automatic logic signed [EW-1:0] edge_of(
        input logic [tfn_pkg::COORD_W-1:0] hi,
        input logic [tfn_pkg::COORD_W-1:0] lo
    );
        return EW'($signed(hi)) - EW'($signed(lo));
    endfunction

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            neg_next[i] = cross_reg[i][CW-1];
            mag_next[i] = neg_next[i] ? MW'(-cross_reg[i]) : MW'(cross_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_valid_reg <= 1'b0;
            p_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            ctl_reg     <= '0;
        end else if (en) begin
            e_valid_reg   <= in_valid;
            p_valid_reg   <= e_valid_reg;
            c_valid_reg   <= p_valid_reg;
            ctl_reg.valid <= c_valid_reg;
            ctl_reg.neg   <= neg_next;
            ctl_reg.degen <= (cross_reg == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ax_reg <= edge_of(in_data.v2_x, in_data.v0_x);
            ay_reg <= edge_of(in_data.v2_y, in_data.v0_y);
            az_reg <= edge_of(in_data.v2_z, in_data.v0_z);
            bx_reg <= edge_of(in_data.v1_x, in_data.v0_x);
            by_reg <= edge_of(in_data.v1_y, in_data.v0_y);
            bz_reg <= edge_of(in_data.v1_z, in_data.v0_z);
            prod_reg[0] <= ay_reg * bz_reg;
            prod_reg[1] <= az_reg * by_reg;
            prod_reg[2] <= az_reg * bx_reg;
            prod_reg[3] <= ax_reg * bz_reg;
            prod_reg[4] <= ax_reg * by_reg;
            prod_reg[5] <= ay_reg * bx_reg;
            cross_reg[0] <= CW'($signed(prod_reg[0])) - CW'($signed(prod_reg[1]));
            cross_reg[1] <= CW'($signed(prod_reg[2])) - CW'($signed(prod_reg[3]));
            cross_reg[2] <= CW'($signed(prod_reg[4])) - CW'($signed(prod_reg[5]));
            mag_reg <= mag_next;
        end
    end

    assign out_ctl = ctl_reg;
    assign out_mag = mag_reg;

endmodule

// File: hw/rtl/tfn_norm_cell.sv
// One binary step of the common left-justify shift
module tfn_norm_cell #(
    parameter int SHIFT = 1
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                en,
    input  tfn_pkg::ctl_t                       in_ctl,
    input  logic [2:0][tfn_pkg::NORM_W-1:0]     in_mag,
    output tfn_pkg::ctl_t                       out_ctl,
    output logic [2:0][tfn_pkg::NORM_W-1:0]     out_mag
);

    localparam int W = tfn_pkg::NORM_W;

    tfn_pkg::ctl_t          ctl_reg;
    logic [2:0][W-1:0]      mag_reg;
    logic                   hit;

    assign hit = ~|{in_mag[0][W-1 -: SHIFT], in_mag[1][W-1 -: SHIFT],
                    in_mag[2][W-1 -: SHIFT]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (en) begin
            ctl_reg <= in_ctl;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                mag_reg[i] <= hit ? (in_mag[i] << SHIFT) : in_mag[i];
            end
        end
    end

    assign out_ctl = ctl_reg;
    assign out_mag = mag_reg;

endmodule

// File: hw/rtl/tfn_sqrt_cell.sv
// One result bit of the restoring square root
module tfn_sqrt_cell (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  tfn_pkg::ctl_t                     in_ctl,
    input  logic [2:0][tfn_pkg::R_W-1:0]      in_r,
    input  logic [tfn_pkg::SUM_W-1:0]         in_s,
    input  logic [tfn_pkg::REM_W-1:0]         in_rem,
    input  logic [tfn_pkg::ROOT_W-1:0]        in_root,
    output tfn_pkg::ctl_t                     out_ctl,
    output logic [2:0][tfn_pkg::R_W-1:0]      out_r,
    output logic [tfn_pkg::SUM_W-1:0]         out_s,
    output logic [tfn_pkg::REM_W-1:0]         out_rem,
    output logic [tfn_pkg::ROOT_W-1:0]        out_root
);

    localparam int RW = tfn_pkg::REM_W;
    localparam int QW = tfn_pkg::ROOT_W;
    localparam int SW = tfn_pkg::SUM_W;

    tfn_pkg::ctl_t              ctl_reg;
    logic [2:0][tfn_pkg::R_W-1:0] r_reg;
    logic [SW-1:0]              s_reg;
    logic [RW-1:0]              rem_reg;
    logic [QW-1:0]              root_reg;
    logic [RW-1:0]              part;
    logic [RW-1:0]              trial;
    logic                       ge;

    assign part  = {in_rem[RW-3:0], in_s[SW-1 -: 2]};
    assign trial = RW'({in_root, 2'b01});
    assign ge    = (part >= trial);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (en) begin
            ctl_reg <= in_ctl;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg    <= in_r;
            s_reg    <= in_s << 2;
            rem_reg  <= ge ? (part - trial) : part;
            root_reg <= {in_root[QW-2:0], ge};
        end
    end

    assign out_ctl  = ctl_reg;
    assign out_r    = r_reg;
    assign out_s    = s_reg;
    assign out_rem  = rem_reg;
    assign out_root = root_reg;

endmodule

// File: hw/rtl/tfn_div_cell.sv
// One quotient bit of three parallel restoring dividers
module tfn_div_cell (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  tfn_pkg::ctl_t                     in_ctl,
    input  logic [tfn_pkg::ROOT_W-1:0]        in_len,
    input  logic [2:0][tfn_pkg::QUO_W-1:0]    in_low,
    input  logic [2:0][tfn_pkg::ROOT_W-1:0]   in_rem,
    input  logic [2:0][tfn_pkg::QUO_W-1:0]    in_quo,
    output tfn_pkg::ctl_t                     out_ctl,
    output logic [tfn_pkg::ROOT_W-1:0]        out_len,
    output logic [2:0][tfn_pkg::QUO_W-1:0]    out_low,
    output logic [2:0][tfn_pkg::ROOT_W-1:0]   out_rem,
    output logic [2:0][tfn_pkg::QUO_W-1:0]    out_quo
);

    localparam int LW = tfn_pkg::ROOT_W;
    localparam int QW = tfn_pkg::QUO_W;

    tfn_pkg::ctl_t          ctl_reg;
    logic [LW-1:0]          len_reg;
    logic [2:0][QW-1:0]     low_reg;
    logic [2:0][LW-1:0]     rem_reg;
    logic [2:0][QW-1:0]     quo_reg;
    logic [2:0][LW:0]       part;
    logic [2:0]             ge;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            part[i] = {in_rem[i], in_low[i][QW-1]};
            ge[i]   = (part[i] >= {1'b0, in_len});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (en) begin
            ctl_reg <= in_ctl;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            len_reg <= in_len;
            for (int i = 0; i < 3; i++) begin
                low_reg[i] <= in_low[i] << 1;
                rem_reg[i] <= ge[i] ? LW'(part[i] - {1'b0, in_len}) : LW'(part[i]);
                quo_reg[i] <= {in_quo[i][QW-2:0], ge[i]};
            end
        end
    end

    assign out_ctl = ctl_reg;
    assign out_len = len_reg;
    assign out_low = low_reg;
    assign out_rem = rem_reg;
    assign out_quo = quo_reg;

endmodule

// File: hw/rtl/triangle_face_normal.sv
// Triangle face normal: takes one triangle per clock while s_ready is high and
// returns its unit normal (a = v2 - v0, b = v1 - v0, n = a x b) in Q1.14; a zero
// cross product gives a zero normal with degenerate set. The pipeline is a row of
// register cells: four front stages, six shift cells that left-justify the three
// magnitudes, two stages for the sum of squares, 32 square root cells (one root bit
// each), one numerator stage, 15 divider cells (one quotient bit each) and the
// output register. The whole row advances together whenever the output register is
// empty or being taken, so a stalled result holds every stage.
module triangle_face_normal (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  tfn_pkg::in_t   s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output tfn_pkg::out_t  m_data
);

    localparam int NW = tfn_pkg::NORM_W;
    localparam int NS = tfn_pkg::NORM_STEPS;
    localparam int RW = tfn_pkg::R_W;
    localparam int QS = tfn_pkg::ROOT_W;
    localparam int DS = tfn_pkg::QUO_W;
    localparam int OW = tfn_pkg::OUT_W;

    logic en;
    logic m_valid_reg;
    tfn_pkg::out_t m_data_reg;

    tfn_pkg::ctl_t                  front_ctl;
    logic [2:0][tfn_pkg::MAG_W-1:0] front_mag;

    tfn_pkg::ctl_t                  n_ctl [NS+1];
    logic [2:0][NW-1:0]             n_mag [NS+1];

    tfn_pkg::ctl_t                  sq_ctl_reg, sum_ctl_reg;
    logic [2:0][RW-1:0]             sq_r_reg, sum_r_reg;
    logic [2:0][tfn_pkg::SQ_W-1:0]  sq_reg;
    logic [tfn_pkg::SUM_W-1:0]      sum_reg;
    logic [2:0][RW-1:0]             r_top;

    tfn_pkg::ctl_t                      q_ctl  [QS+1];
    logic [2:0][RW-1:0]                 q_r    [QS+1];
    logic [tfn_pkg::SUM_W-1:0]          q_s    [QS+1];
    logic [tfn_pkg::REM_W-1:0]          q_rem  [QS+1];
    logic [tfn_pkg::ROOT_W-1:0]         q_root [QS+1];

    tfn_pkg::ctl_t                      d_ctl [DS+1];
    logic [tfn_pkg::ROOT_W-1:0]         d_len [DS+1];
    logic [2:0][DS-1:0]                 d_low [DS+1];
    logic [2:0][tfn_pkg::ROOT_W-1:0]    d_rem [DS+1];
    logic [2:0][DS-1:0]                 d_quo [DS+1];

    tfn_pkg::ctl_t                      prep_ctl_reg;
    logic [tfn_pkg::ROOT_W-1:0]         prep_len_reg;
    logic [2:0][DS-1:0]                 prep_low_reg;
    logic [2:0][tfn_pkg::ROOT_W-1:0]    prep_rem_reg;
    logic [2:0][tfn_pkg::NUM_W-1:0]     num;

    logic [2:0][DS-1:0]                 q_cap;
    logic [2:0][OW-1:0]                 comp;
    tfn_pkg::out_t                      m_data_next;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    tfn_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_valid),
        .in_data  (s_data),
        .out_ctl  (front_ctl),
        .out_mag  (front_mag)
    );

    assign n_ctl[0] = front_ctl;
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_mag[0][i] = NW'(front_mag[i]);
        end
    end

    for (genvar g = 0; g < NS; g++) begin : g_norm
        tfn_norm_cell #(
            .SHIFT (1 << (NS - 1 - g))
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .in_ctl  (n_ctl[g]),
            .in_mag  (n_mag[g]),
            .out_ctl (n_ctl[g+1]),
            .out_mag (n_mag[g+1])
        );
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            r_top[i] = n_mag[NS][i][NW-1 -: RW];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_ctl_reg  <= '0;
            sum_ctl_reg <= '0;
        end else if (en) begin
            sq_ctl_reg  <= n_ctl[NS];
            sum_ctl_reg <= sq_ctl_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_r_reg <= r_top;
            for (int i = 0; i < 3; i++) begin
                sq_reg[i] <= r_top[i] * r_top[i];
            end
            sum_r_reg <= sq_r_reg;
            sum_reg   <= tfn_pkg::SUM_W'(sq_reg[0]) + tfn_pkg::SUM_W'(sq_reg[1])
                       + tfn_pkg::SUM_W'(sq_reg[2]);
        end
    end

    assign q_ctl[0]  = sum_ctl_reg;
    assign q_r[0]    = sum_r_reg;
    assign q_s[0]    = sum_reg;
    assign q_rem[0]  = '0;
    assign q_root[0] = '0;

    for (genvar g = 0; g < QS; g++) begin : g_sqrt
        tfn_sqrt_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .in_ctl   (q_ctl[g]),
            .in_r     (q_r[g]),
            .in_s     (q_s[g]),
            .in_rem   (q_rem[g]),
            .in_root  (q_root[g]),
            .out_ctl  (q_ctl[g+1]),
            .out_r    (q_r[g+1]),
            .out_s    (q_s[g+1]),
            .out_rem  (q_rem[g+1]),
            .out_root (q_root[g+1])
        );
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            num[i] = (tfn_pkg::NUM_W'(q_r[QS][i]) << tfn_pkg::FRAC_SH)
                   + tfn_pkg::NUM_W'(q_root[QS] >> 1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prep_ctl_reg <= '0;
        end else if (en) begin
            prep_ctl_reg <= q_ctl[QS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prep_len_reg <= q_root[QS];
            for (int i = 0; i < 3; i++) begin
                prep_low_reg[i] <= num[i][DS-1:0];
                prep_rem_reg[i] <= tfn_pkg::ROOT_W'(num[i][tfn_pkg::NUM_W-1:DS]);
            end
        end
    end

    assign d_ctl[0] = prep_ctl_reg;
    assign d_len[0] = prep_len_reg;
    assign d_low[0] = prep_low_reg;
    assign d_rem[0] = prep_rem_reg;
    assign d_quo[0] = '0;

    for (genvar g = 0; g < DS; g++) begin : g_div
        tfn_div_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .in_ctl  (d_ctl[g]),
            .in_len  (d_len[g]),
            .in_low  (d_low[g]),
            .in_rem  (d_rem[g]),
            .in_quo  (d_quo[g]),
            .out_ctl (d_ctl[g+1]),
            .out_len (d_len[g+1]),
            .out_low (d_low[g+1]),
            .out_rem (d_rem[g+1]),
            .out_quo (d_quo[g+1])
        );
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            q_cap[i] = (d_quo[DS][i] > tfn_pkg::NORM_ONE) ? tfn_pkg::NORM_ONE
                                                          : d_quo[DS][i];
            if (d_ctl[DS].degen) begin
                comp[i] = '0;
            end else if (d_ctl[DS].neg[i]) begin
                comp[i] = OW'(-OW'(q_cap[i]));
            end else begin
                comp[i] = OW'(q_cap[i]);
            end
        end
        m_data_next.normal_x   = comp[0];
        m_data_next.normal_y   = comp[1];
        m_data_next.normal_z   = comp[2];
        m_data_next.degenerate = d_ctl[DS].degen;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= d_ctl[DS].valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: hw/rtl/tfn_checker.sv
// Port-level checks of the face normal block and their bind
`include "assert_macros.svh"

module tfn_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_ready,
    input logic          m_valid,
    input logic          m_ready,
    input tfn_pkg::out_t m_data
);

    logic normal_zero;
    logic normal_in_range;
    logic out_stall;
    logic out_free;

    function automatic logic unit_ok(input logic [tfn_pkg::OUT_W-1:0] c);
        return ($signed(c) <= 16'sd16384) && ($signed(c) >= -16'sd16384);
    endfunction

    assign normal_zero = (m_data.normal_x == '0) && (m_data.normal_y == '0)
                       && (m_data.normal_z == '0);
    assign normal_in_range = unit_ok(m_data.normal_x) && unit_ok(m_data.normal_y)
                           && unit_ok(m_data.normal_z);
    assign out_stall = m_valid && !m_ready;
    assign out_free  = !m_valid || m_ready;

    `TFN_ASSERT_NEXT(a_out_hold, aclk, aresetn, out_stall, m_valid && $stable(m_data))

    `TFN_ASSERT_IMPL(a_degen_zero, aclk, aresetn, m_valid && m_data.degenerate, normal_zero)

    `TFN_ASSERT_IMPL(a_unit_range, aclk, aresetn, m_valid, normal_in_range)

    `TFN_ASSERT_IMPL(a_ready_free, aclk, aresetn, out_free, s_ready)

    `TFN_ASSERT_NEXT(a_reset_empty, aclk, 1'b1, !aresetn, !m_valid)

endmodule

bind triangle_face_normal tfn_checker u_tfn_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
